// File: design/mlpq_pkg.sv
// Package for the multi-level priority queue.
// Default sizes, status codes and the response struct; no dependencies.
package mlpq_pkg;

  localparam int NUM_LEVELS_DEF  = 3;
  localparam int LEVEL_DEPTH_DEF = 4;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int STATUS_W = 2;
  localparam int OLEVEL_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic                strobe;
    logic [STATUS_W-1:0] status;
    logic [OLEVEL_W-1:0] level;
    logic                hit;
  } mlpq_resp_t;

endpackage

// File: design/mlpq_mem.sv
// Slot memory of the priority queue: one write port, one read port,
// registered read data. Depends on nothing.
module mlpq_mem #(
  parameter int DEPTH = 12,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/mlpq_ctrl.sv
// Level pointers, busy bits and priority select of the priority queue.
// Issues slot memory accesses and registers the response; uses mlpq_pkg.
module mlpq_ctrl #(
  parameter int NUM_LEVELS  = 3,
  parameter int LEVEL_DEPTH = 4,
  parameter int DATA_WIDTH  = 32,
  parameter int AW          = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_mode,
  input  logic [1:0]             in_level,
  input  logic [31:0]            in_value,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [DATA_WIDTH-1:0]  mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  output mlpq_pkg::mlpq_resp_t   resp
);
  import mlpq_pkg::*;

  localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int LW_EXT = (LVL_W > 2) ? LVL_W + 1 : 3;

  logic [PTR_W-1:0]      head_r [NUM_LEVELS];
  logic [PTR_W-1:0]      tail_r [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] lbusy_r;
  logic                  busy_r;
  mlpq_resp_t            resp_r;
  mlpq_resp_t            resp_nxt;

  logic             accept;
  logic             ins;
  logic             lvl_ok;
  logic [LVL_W-1:0] li;
  logic [LVL_W-1:0] rl;
  logic             found;
  logic [LVL_W-1:0] sel;
  logic [PTR_W-1:0] head_sel;
  logic [PTR_W-1:0] tail_sel;
  logic             sel_busy;
  logic             full;
  logic             ins_ok;
  logic             rem_ok;
  logic [PTR_W-1:0] new_tail;
  logic             drain;
  logic [63:0]      val_ext;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign ins    = (in_mode == MODE_INSERT);
  assign li     = LVL_W'(in_level);
  assign lvl_ok = LW_EXT'(in_level) < LW_EXT'(NUM_LEVELS);

  always_comb begin
    rl    = '0;
    found = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (lbusy_r[i]) begin
        rl    = LVL_W'(i);
        found = 1'b1;
      end
    end
  end

  assign sel      = ins ? li : rl;
  assign head_sel = head_r[sel];
  assign tail_sel = tail_r[sel];
  assign sel_busy = lbusy_r[sel];
  assign full     = sel_busy && (tail_sel == PTR_W'(LEVEL_DEPTH - 1));
  assign ins_ok   = accept && ins && lvl_ok && !full;
  assign rem_ok   = accept && !ins && found;
  assign new_tail = sel_busy ? tail_sel + PTR_W'(1) : '0;
  assign drain    = (head_sel >= tail_sel);
  assign val_ext  = 64'($unsigned(in_value));

  assign mem_we    = ins_ok;
  assign mem_waddr = AW'(sel) * AW'(LEVEL_DEPTH) + AW'(new_tail);
  assign mem_wdata = DATA_WIDTH'(val_ext);
  assign mem_re    = rem_ok;
  assign mem_raddr = AW'(sel) * AW'(LEVEL_DEPTH) + AW'(head_sel);

  always_comb begin
    resp_nxt        = '0;
    resp_nxt.strobe = accept;
    priority if (ins) begin
      resp_nxt.status = ins_ok ? ST_OK : ST_OVERFLOW;
    end else if (found) begin
      resp_nxt.status = ST_OK;
      resp_nxt.level  = OLEVEL_W'(rl);
      resp_nxt.hit    = 1'b1;
    end else begin
      resp_nxt.status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      lbusy_r <= '0;
      resp_r  <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      busy_r <= 1'b0;
      resp_r <= resp_nxt;
      if (ins_ok) begin
        tail_r[sel]  <= new_tail;
        lbusy_r[sel] <= 1'b1;
        if (!sel_busy) begin
          head_r[sel] <= '0;
        end
      end else if (rem_ok) begin
        if (drain) begin
          lbusy_r[sel] <= 1'b0;
          head_r[sel]  <= '0;
          tail_r[sel]  <= '0;
        end else begin
          head_r[sel] <= head_sel + PTR_W'(1);
        end
      end
    end
  end

  assign resp = resp_r;

endmodule

// File: design/multi_level_priority_queue.sv
// Top level of the multi-level priority queue.
// Instantiates mlpq_ctrl and mlpq_mem; uses mlpq_pkg.
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------
// input    | start / busy         | in_mode, in_level, in_value
// result   | out_strobe           | out_status, out_value, out_level
//
// One item per cycle while busy is low; its result strobes in the cycle after acceptance,
// when the slot memory's registered read data is valid.
// Busy is high during reset and in the cycle after it; otherwise low.
// Level pointers are flops; words sit in a single-port-write, single-read memory.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multi_level_priority_queue #(
  parameter int NUM_LEVELS  = mlpq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = mlpq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [1:0]         in_level,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_level
);
  import mlpq_pkg::*;

  localparam int DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  mlpq_resp_t            resp;
  logic [63:0]           rdata_ext;

  mlpq_ctrl #(
    .NUM_LEVELS (NUM_LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_mode  (in_mode),
    .in_level (in_level),
    .in_value (in_value),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .resp     (resp)
  );

  mlpq_mem #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (DATA_WIDTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rdata_ext  = 64'(mem_rdata);
  assign out_strobe = resp.strobe;
  assign out_status = resp.status;
  assign out_level  = resp.level;
  assign out_value  = resp.hit ? signed'(rdata_ext[31:0]) : '0;

endmodule

// File: design/mlpq_checker.sv
// Port-level checker for the multi-level priority queue, bound to the top.
// Uses mlpq_pkg status and mode codes.
module mlpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_mode,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [31:0] out_value,
  input logic [1:0]  out_level
);
  import mlpq_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted item gave no result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept))
    else $error("result without an accepted item");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_value == '0 && out_level == '0))
    else $error("failed item returned data");

  a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_INSERT) |=> (out_status != ST_EMPTY && out_value == '0))
    else $error("insert gave a remove-only result");

  a_remove_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_REMOVE) |=> (out_status != ST_OVERFLOW))
    else $error("remove gave overflow");

endmodule

bind multi_level_priority_queue mlpq_checker u_mlpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_strobe(out_strobe),
  .out_status(out_status),
  .out_value (out_value),
  .out_level (out_level)
);
